[rtl/core/assert_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low
`define RVID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define RVID_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rvid_pkg.sv]
// Types and constants of the RV32I instruction decoder.
package rvid_pkg;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int OP_W       = 6;
    localparam int REG_W      = 5;
    localparam int IMM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATOMIC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULDIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CSR     = 3'd4;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_AMO    = 7'b0101111;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;

    // funct3 codes: arithmetic
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    // funct3 codes: branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    // funct3 codes: loads and stores
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_D    = 3'd3;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;
    localparam logic [2:0] F3_B    = 3'd0;
    // funct3 codes: system, fence, atomics
    localparam logic [2:0] F3_PRIV  = 3'd0;
    localparam logic [2:0] F3_CSRRW = 3'd1;
    localparam logic [2:0] F3_CSRRS = 3'd2;
    localparam logic [2:0] F3_FENCE = 3'd0;
    localparam logic [2:0] F3_AMO_W = 3'd2;

    // funct7 and immediate codes
    localparam logic [6:0]  F7_BASE    = 7'b0000000;
    localparam logic [6:0]  F7_ALT     = 7'b0100000;
    localparam logic [6:0]  F7_MUL     = 7'b0000001;
    localparam logic [11:0] MRET_IMM   = 12'b001100000010;
    localparam logic [5:0]  SH6_SRA    = 6'b010000;
    localparam logic [5:0]  SH6_BASE   = 6'b000000;

    // Operation numbers
    typedef enum logic [OP_W-1:0] {
        OP_LUI, OP_AUIPC, OP_FENCE, OP_AMOSWAP_W, OP_ADDI, OP_SLLI, OP_SRAI,
        OP_SRLI, OP_SLTIU, OP_XORI, OP_ANDI, OP_ORI, OP_ADDIW, OP_SUB, OP_ADD,
        OP_MUL, OP_SLL, OP_MULH, OP_SLTU, OP_MULHU, OP_SRL, OP_SRA, OP_AND,
        OP_XOR, OP_DIV, OP_OR, OP_REM, OP_JAL, OP_JALR, OP_MRET, OP_ECALL,
        OP_CSRRS, OP_CSRRW, OP_BEQ, OP_BNE, OP_BLT, OP_BLTU, OP_BGEU, OP_BGE,
        OP_LW, OP_LBU, OP_LH, OP_LHU, OP_LD, OP_SB, OP_SH, OP_SW, OP_SD
    } t_op;

    // Enable registers
    typedef struct packed {
        logic atomic_enable;
        logic wide_mode;
        logic muldiv_enable;
        logic privileged_enable;
        logic csr_enable;
    } t_cfg;

    // One decoded result
    typedef struct packed {
        t_op                     operation;
        logic                    illegal;
        logic [REG_W-1:0]        dest_reg;
        logic                    dest_used;
        logic [REG_W-1:0]        src1_reg;
        logic                    src1_used;
        logic [REG_W-1:0]        src2_reg;
        logic                    src2_used;
        logic signed [IMM_W-1:0] immediate;
    } t_dec;

endpackage

[rtl/core/rvid_if.sv]
// Valid/ready channel interfaces for instruction words and decoded results.
interface rvid_in_if
    import rvid_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvid_out_if
    import rvid_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic                    illegal;
    logic [REG_W-1:0]        dest_reg;
    logic                    dest_used;
    logic [REG_W-1:0]        src1_reg;
    logic                    src1_used;
    logic [REG_W-1:0]        src2_reg;
    logic                    src2_used;
    logic signed [IMM_W-1:0] immediate;

    modport source (
        output valid, output operation, output illegal, output dest_reg,
        output dest_used, output src1_reg, output src1_used, output src2_reg,
        output src2_used, output immediate, input ready
    );
    modport sink (
        input valid, input operation, input illegal, input dest_reg,
        input dest_used, input src1_reg, input src1_used, input src2_reg,
        input src2_used, input immediate, output ready
    );
endinterface

[rtl/core/riscv_instruction_decoder.sv]
// RV32I instruction decoder: input register, decode logic, result register.
//
// Usage:
//   i_in carries one 32-bit instruction word per beat; o_out carries one
//   decoded result per beat (operation, illegal flag, register indices with
//   used flags, immediate). Both are valid/ready channels.
//   The enable registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data; the user must write them only while no word is in flight,
//   as the block itself does not enforce it. They steer the next decodes.
// Pipeline: input register, then result register with the decode between them.
// Throughput: one word per cycle; the two-register pipeline takes a new beat
//   every cycle while the receiver keeps ready high.
// Stall: when o_out.ready is low the result register holds; an empty input
//   register still takes one more beat, then i_in.ready drops.
// Reset: synchronous, active low; clears both valid flags and all enable
//   registers, so extensions start disabled.
module riscv_instruction_decoder
    import rvid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rvid_in_if.sink               i_in,
    rvid_out_if.source            o_out
);

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic              r_out_valid;
    t_dec              r_out;
    t_dec              n_out;
    logic              out_free;
    logic              in_ready;

    logic [6:0]        opcode;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [11:0]       imm12;
    logic [IMM_W-1:0]  imm_i;
    logic [IMM_W-1:0]  imm_s;
    logic [IMM_W-1:0]  imm_b;
    logic [IMM_W-1:0]  imm_j;
    logic [IMM_W-1:0]  shamt;
    logic              sh_base;
    logic              sh_alt;

    // Handshake: result register frees when empty or taken
    assign out_free   = !r_out_valid || o_out.ready;
    assign in_ready   = !r_in_valid || out_free;
    assign i_in.ready = in_ready;

    // Configuration write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATOMIC: n_cfg.atomic_enable     = i_cfg_data[0];
                CFG_WIDE:   n_cfg.wide_mode         = i_cfg_data[0];
                CFG_MULDIV: n_cfg.muldiv_enable     = i_cfg_data[0];
                CFG_PRIV:   n_cfg.privileged_enable = i_cfg_data[0];
                CFG_CSR:    n_cfg.csr_enable        = i_cfg_data[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    // Instruction fields and immediates
    assign opcode = r_in_word[6:0];
    assign f3     = r_in_word[14:12];
    assign f7     = r_in_word[31:25];
    assign imm12  = r_in_word[31:20];
    assign imm_i  = {{20{r_in_word[31]}}, imm12};
    assign imm_s  = {{20{r_in_word[31]}}, r_in_word[31:25], r_in_word[11:7]};
    assign imm_b  = {{20{r_in_word[31]}}, r_in_word[7], r_in_word[30:25],
                     r_in_word[11:8], 1'b0};
    assign imm_j  = {{12{r_in_word[31]}}, r_in_word[19:12], r_in_word[20],
                     r_in_word[30:21], 1'b0};

    // Shift-immediate kind and amount follow the word width
    always_comb begin
        if (r_cfg.wide_mode) begin
            shamt   = {26'd0, imm12[5:0]};
            sh_base = (imm12[11:6] == SH6_BASE);
            sh_alt  = (imm12[11:6] == SH6_SRA);
        end else begin
            shamt   = {27'd0, imm12[4:0]};
            sh_base = (imm12[11:5] == F7_BASE);
            sh_alt  = (imm12[11:5] == F7_ALT);
        end
    end

    // Decode one word
    always_comb begin
        logic             bad;
        logic             rd_u;
        logic             rs1_u;
        logic             rs2_u;
        logic             mul_ok;
        t_op              op;
        logic [IMM_W-1:0] imm;

        bad    = 1'b0;
        rd_u   = 1'b0;
        rs1_u  = 1'b0;
        rs2_u  = 1'b0;
        op     = OP_LUI;
        imm    = '0;
        mul_ok = r_cfg.muldiv_enable && (f7 == F7_MUL);

        case (opcode)
            OPC_LUI, OPC_AUIPC: begin
                rd_u = 1'b1;
                imm  = {r_in_word[31:12], 12'd0};
                op   = (opcode == OPC_LUI) ? OP_LUI : OP_AUIPC;
            end
            OPC_FENCE: begin
                rd_u  = 1'b1;
                rs1_u = 1'b1;
                imm   = imm_i;
                if (f3 == F3_FENCE) op = OP_FENCE;
                else bad = 1'b1;
            end
            OPC_AMO: begin
                if (!r_cfg.atomic_enable) begin
                    bad = 1'b1;
                end else begin
                    rd_u  = 1'b1;
                    rs1_u = 1'b1;
                    rs2_u = 1'b1;
                    imm   = {25'd0, f7};
                    if (f3 == F3_AMO_W) op = OP_AMOSWAP_W;
                    else bad = 1'b1;
                end
            end
            OPC_OPIMM: begin
                rd_u  = 1'b1;
                rs1_u = 1'b1;
                imm   = imm_i;
                case (f3)
                    F3_ADD:  op = OP_ADDI;
                    F3_SLL: begin
                        imm = shamt;
                        if (sh_base) op = OP_SLLI;
                        else bad = 1'b1;
                    end
                    F3_SR: begin
                        imm = shamt;
                        if (sh_alt) op = OP_SRAI;
                        else if (sh_base) op = OP_SRLI;
                        else bad = 1'b1;
                    end
                    F3_SLTU: op = OP_SLTIU;
                    F3_XOR:  op = OP_XORI;
                    F3_AND:  op = OP_ANDI;
                    F3_OR:   op = OP_ORI;
                    default: bad = 1'b1;
                endcase
            end
            OPC_OPIMMW: begin
                if (!r_cfg.wide_mode) begin
                    bad = 1'b1;
                end else begin
                    rd_u  = 1'b1;
                    rs1_u = 1'b1;
                    imm   = imm_i;
                    if (f3 == F3_ADD) op = OP_ADDIW;
                    else bad = 1'b1;
                end
            end
            OPC_OP: begin
                rd_u  = 1'b1;
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_ALT) op = OP_SUB;
                        else if (f7 == F7_BASE) op = OP_ADD;
                        else if (mul_ok) op = OP_MUL;
                        else bad = 1'b1;
                    end
                    F3_SLL: begin
                        if (f7 == F7_BASE) op = OP_SLL;
                        else if (mul_ok) op = OP_MULH;
                        else bad = 1'b1;
                    end
                    F3_SLTU: begin
                        if (f7 == F7_BASE) op = OP_SLTU;
                        else if (mul_ok) op = OP_MULHU;
                        else bad = 1'b1;
                    end
                    F3_SR: begin
                        if (f7 == F7_BASE) op = OP_SRL;
                        else if (f7 == F7_ALT) op = OP_SRA;
                        else bad = 1'b1;
                    end
                    F3_AND: begin
                        if (f7 == F7_BASE) op = OP_AND;
                        else bad = 1'b1;
                    end
                    F3_XOR: begin
                        if (f7 == F7_BASE) op = OP_XOR;
                        else if (mul_ok) op = OP_DIV;
                        else bad = 1'b1;
                    end
                    F3_OR: begin
                        if (f7 == F7_BASE) op = OP_OR;
                        else if (mul_ok) op = OP_REM;
                        else bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_JAL: begin
                rd_u = 1'b1;
                op   = OP_JAL;
                imm  = imm_j;
            end
            OPC_JALR: begin
                rd_u  = 1'b1;
                rs1_u = 1'b1;
                imm   = imm_i;
                op    = OP_JALR;
            end
            OPC_SYSTEM: begin
                rd_u  = 1'b1;
                rs1_u = 1'b1;
                if (f3 == F3_PRIV) begin
                    imm = imm_i;
                    op  = (r_cfg.privileged_enable && imm12 == MRET_IMM) ? OP_MRET
                                                                          : OP_ECALL;
                end else if (r_cfg.csr_enable && f3 == F3_CSRRS) begin
                    imm = {20'd0, imm12};
                    op  = OP_CSRRS;
                end else if (r_cfg.csr_enable && f3 == F3_CSRRW) begin
                    imm = {20'd0, imm12};
                    op  = OP_CSRRW;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_BRANCH: begin
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                imm   = imm_b;
                case (f3)
                    F3_BEQ:  op = OP_BEQ;
                    F3_BNE:  op = OP_BNE;
                    F3_BLT:  op = OP_BLT;
                    F3_BLTU: op = OP_BLTU;
                    F3_BGEU: op = OP_BGEU;
                    F3_BGE:  op = OP_BGE;
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                rd_u  = 1'b1;
                rs1_u = 1'b1;
                imm   = imm_i;
                if (f3 == F3_W) op = OP_LW;
                else if (f3 == F3_BU) op = OP_LBU;
                else if (f3 == F3_H) op = OP_LH;
                else if (f3 == F3_HU) op = OP_LHU;
                else if (f3 == F3_D && r_cfg.wide_mode) op = OP_LD;
                else bad = 1'b1;
            end
            OPC_STORE: begin
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                imm   = imm_s;
                if (f3 == F3_B) op = OP_SB;
                else if (f3 == F3_H) op = OP_SH;
                else if (f3 == F3_W) op = OP_SW;
                else if (f3 == F3_D && r_cfg.wide_mode) op = OP_SD;
                else bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase

        // Drop every field of an illegal word; zero unused indices
        n_out = '0;
        if (bad) begin
            n_out.illegal = 1'b1;
        end else begin
            n_out.operation = op;
            n_out.dest_used = rd_u;
            n_out.src1_used = rs1_u;
            n_out.src2_used = rs2_u;
            n_out.dest_reg  = rd_u  ? r_in_word[11:7]  : '0;
            n_out.src1_reg  = rs1_u ? r_in_word[19:15] : '0;
            n_out.src2_reg  = rs2_u ? r_in_word[24:20] : '0;
            n_out.immediate = imm;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers: capture word, advance result
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_word <= i_in.instruction_word;
        end
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // Result channel
    assign o_out.valid     = r_out_valid;
    assign o_out.operation = r_out.operation;
    assign o_out.illegal   = r_out.illegal;
    assign o_out.dest_reg  = r_out.dest_reg;
    assign o_out.dest_used = r_out.dest_used;
    assign o_out.src1_reg  = r_out.src1_reg;
    assign o_out.src1_used = r_out.src1_used;
    assign o_out.src2_reg  = r_out.src2_reg;
    assign o_out.src2_used = r_out.src2_used;
    assign o_out.immediate = r_out.immediate;

endmodule

[rtl/core/rvid_checker.sv]
// Port-level checker for the instruction decoder, with its bind.
`include "assert_macros.svh"

module rvid_checker
    import rvid_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [OP_W-1:0]         i_operation,
    input logic                    i_illegal,
    input logic [REG_W-1:0]        i_dest_reg,
    input logic                    i_dest_used,
    input logic [REG_W-1:0]        i_src1_reg,
    input logic                    i_src1_used,
    input logic [REG_W-1:0]        i_src2_reg,
    input logic                    i_src2_used,
    input logic signed [IMM_W-1:0] i_immediate
);

    // No result straight after a reset cycle
    `RVID_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // An illegal beat carries nothing else
    `RVID_ASSERT(a_illegal_zero, i_clk, i_rst_n, i_out_valid && i_illegal |-> i_operation == '0 && !i_dest_used && !i_src1_used && !i_src2_used && i_immediate == '0, "illegal beat with fields set")

    // Unused register indices read as zero
    `RVID_ASSERT(a_unused_zero, i_clk, i_rst_n, i_out_valid |-> (i_dest_used || i_dest_reg == '0) && (i_src1_used || i_src1_reg == '0) && (i_src2_used || i_src2_reg == '0), "unused index not zero")

    // A free receiver never stalls the input side
    `RVID_ASSERT(a_flow, i_clk, i_rst_n, i_out_ready |-> i_in_ready, "input stalled while output ready")

    // Hold a stalled result
    `RVID_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_operation) && $stable(i_immediate) && $stable(i_illegal), "stalled result changed")

endmodule

bind riscv_instruction_decoder rvid_checker u_rvid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_operation (o_out.operation),
    .i_illegal   (o_out.illegal),
    .i_dest_reg  (o_out.dest_reg),
    .i_dest_used (o_out.dest_used),
    .i_src1_reg  (o_out.src1_reg),
    .i_src1_used (o_out.src1_used),
    .i_src2_reg  (o_out.src2_reg),
    .i_src2_used (o_out.src2_used),
    .i_immediate (o_out.immediate)
);

[test/tb_riscv_instruction_decoder.sv]
// Testbench for the RV32I instruction decoder: directed and random words against a decode predictor.
`timescale 1ns / 100ps

module tb_riscv_instruction_decoder;
    import rvid_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_WORDS  = 240;

    typedef struct {
        logic [WORD_W-1:0] word;
        t_dec              dec;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rvid_in_if  in_if ();
    rvid_out_if out_if ();

    t_pending pending_decodes[$];
    t_cfg     enables;
    bit       calm = 1'b0;
    int       mismatches = 0;
    int       cycle_count = 0;

    riscv_instruction_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Predict the decode of one word under the given enables
    function automatic t_dec predict_decode(input logic [WORD_W-1:0] w, input t_cfg c);
        t_dec d;
        t_op op;
        logic [6:0] opc;
        logic [6:0] f7;
        logic [2:0] f3;
        logic [11:0] imm12;
        logic [6:0] kind;
        logic [IMM_W-1:0] shamt;
        logic [IMM_W-1:0] ii;
        logic [IMM_W-1:0] imm;
        logic bad, rd_u, rs1_u, rs2_u, m;
        opc = w[6:0];
        f3 = w[14:12];
        f7 = w[31:25];
        imm12 = w[31:20];
        ii = {{20{imm12[11]}}, imm12};
        bad = 1'b0;
        rd_u = 1'b0;
        rs1_u = 1'b0;
        rs2_u = 1'b0;
        op = OP_LUI;
        imm = '0;
        case (opc)
            OPC_LUI, OPC_AUIPC: begin
                rd_u = 1'b1;
                imm = {w[31:12], 12'b0};
                if (opc == OPC_LUI) op = OP_LUI;
                else op = OP_AUIPC;
            end
            OPC_FENCE: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                imm = ii;
                if (f3 == F3_FENCE) op = OP_FENCE;
                else bad = 1'b1;
            end
            OPC_AMO: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                imm = {25'b0, f7};
                if (c.atomic_enable && f3 == F3_AMO_W) op = OP_AMOSWAP_W;
                else bad = 1'b1;
            end
            OPC_OPIMM: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                imm = ii;
                // Shift amount and the bits above it depend on the word size
                if (c.wide_mode) begin
                    kind = {1'b0, imm12[11:6]};
                    shamt = {26'b0, imm12[5:0]};
                end else begin
                    kind = imm12[11:5];
                    shamt = {27'b0, imm12[4:0]};
                end
                case (f3)
                    F3_ADD:  op = OP_ADDI;
                    F3_SLL: begin
                        imm = shamt;
                        if (kind == F7_BASE) op = OP_SLLI;
                        else bad = 1'b1;
                    end
                    F3_SR: begin
                        imm = shamt;
                        if (kind == (c.wide_mode ? {1'b0, SH6_SRA} : F7_ALT)) op = OP_SRAI;
                        else if (kind == F7_BASE) op = OP_SRLI;
                        else bad = 1'b1;
                    end
                    F3_SLTU: op = OP_SLTIU;
                    F3_XOR:  op = OP_XORI;
                    F3_AND:  op = OP_ANDI;
                    F3_OR:   op = OP_ORI;
                    default: bad = 1'b1;
                endcase
            end
            OPC_OPIMMW: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                imm = ii;
                if (c.wide_mode && f3 == F3_ADD) op = OP_ADDIW;
                else bad = 1'b1;
            end
            OPC_OP: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                m = c.muldiv_enable && f7 == F7_MUL;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_ALT) op = OP_SUB;
                        else if (f7 == F7_BASE) op = OP_ADD;
                        else if (m) op = OP_MUL;
                        else bad = 1'b1;
                    end
                    F3_SLL: begin
                        if (f7 == F7_BASE) op = OP_SLL;
                        else if (m) op = OP_MULH;
                        else bad = 1'b1;
                    end
                    F3_SLTU: begin
                        if (f7 == F7_BASE) op = OP_SLTU;
                        else if (m) op = OP_MULHU;
                        else bad = 1'b1;
                    end
                    F3_SR: begin
                        if (f7 == F7_BASE) op = OP_SRL;
                        else if (f7 == F7_ALT) op = OP_SRA;
                        else bad = 1'b1;
                    end
                    F3_AND: begin
                        if (f7 == F7_BASE) op = OP_AND;
                        else bad = 1'b1;
                    end
                    F3_XOR: begin
                        if (f7 == F7_BASE) op = OP_XOR;
                        else if (m) op = OP_DIV;
                        else bad = 1'b1;
                    end
                    F3_OR: begin
                        if (f7 == F7_BASE) op = OP_OR;
                        else if (m) op = OP_REM;
                        else bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OPC_JAL: begin
                rd_u = 1'b1;
                op = OP_JAL;
                imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                imm = ii;
                op = OP_JALR;
            end
            OPC_SYSTEM: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                if (f3 == F3_PRIV) begin
                    imm = ii;
                    if (c.privileged_enable && imm12 == MRET_IMM) op = OP_MRET;
                    else op = OP_ECALL;
                end else if (c.csr_enable && f3 == F3_CSRRS) begin
                    imm = {20'b0, imm12};
                    op = OP_CSRRS;
                end else if (c.csr_enable && f3 == F3_CSRRW) begin
                    imm = {20'b0, imm12};
                    op = OP_CSRRW;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_BRANCH: begin
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  op = OP_BEQ;
                    F3_BNE:  op = OP_BNE;
                    F3_BLT:  op = OP_BLT;
                    F3_BLTU: op = OP_BLTU;
                    F3_BGEU: op = OP_BGEU;
                    F3_BGE:  op = OP_BGE;
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD: begin
                rd_u = 1'b1;
                rs1_u = 1'b1;
                imm = ii;
                if (f3 == F3_W) op = OP_LW;
                else if (f3 == F3_BU) op = OP_LBU;
                else if (f3 == F3_H) op = OP_LH;
                else if (f3 == F3_HU) op = OP_LHU;
                else if (f3 == F3_D && c.wide_mode) op = OP_LD;
                else bad = 1'b1;
            end
            OPC_STORE: begin
                rs1_u = 1'b1;
                rs2_u = 1'b1;
                imm = {{20{w[31]}}, w[31:25], w[11:7]};
                if (f3 == F3_B) op = OP_SB;
                else if (f3 == F3_H) op = OP_SH;
                else if (f3 == F3_W) op = OP_SW;
                else if (f3 == F3_D && c.wide_mode) op = OP_SD;
                else bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase

        // Illegal words carry nothing but the flag
        d = '0;
        if (bad) begin
            d.illegal = 1'b1;
        end else begin
            d.operation = op;
            d.dest_reg  = rd_u ? w[11:7] : '0;
            d.dest_used = rd_u;
            d.src1_reg  = rs1_u ? w[19:15] : '0;
            d.src1_used = rs1_u;
            d.src2_reg  = rs2_u ? w[24:20] : '0;
            d.src2_used = rs2_u;
            d.immediate = imm;
        end
        return d;
    endfunction

    function automatic logic [WORD_W-1:0] encode(input logic [6:0] f7, input logic [4:0] rs2,
                                                 input logic [4:0] rs1, input logic [2:0] f3,
                                                 input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // Mostly well-formed words with random fields, some raw noise
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        logic [6:0] f7;
        w = $urandom;
        if ($urandom_range(0, 99) < 10) return w;
        case ($urandom_range(0, 12))
            0:  w[6:0] = OPC_LUI;
            1:  w[6:0] = OPC_AUIPC;
            2:  w[6:0] = OPC_FENCE;
            3:  w[6:0] = OPC_AMO;
            4:  w[6:0] = OPC_OPIMM;
            5:  w[6:0] = OPC_OPIMMW;
            6:  w[6:0] = OPC_OP;
            7:  w[6:0] = OPC_JAL;
            8:  w[6:0] = OPC_JALR;
            9:  w[6:0] = OPC_SYSTEM;
            10: w[6:0] = OPC_BRANCH;
            11: w[6:0] = OPC_LOAD;
            default: w[6:0] = OPC_STORE;
        endcase
        // Bias the top bits towards the codes the decoder looks for
        case ($urandom_range(0, 4))
            0: f7 = F7_BASE;
            1: f7 = F7_ALT;
            2: f7 = F7_MUL;
            3: f7 = {F7_ALT[6:1], w[25]};
            default: f7 = w[31:25];
        endcase
        w[31:25] = f7;
        if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 2) == 0) w[31:20] = MRET_IMM;
        return w;
    endfunction

    function automatic string show_dec(input t_dec d);
        return $sformatf("op=%0d ill=%b rd=%0d/%b rs1=%0d/%b rs2=%0d/%b imm=%h",
                         d.operation, d.illegal, d.dest_reg, d.dest_used, d.src1_reg,
                         d.src1_used, d.src2_reg, d.src2_used, d.immediate);
    endfunction

    // Send one word, at times after a random gap, and hold it until taken
    task automatic send_word(input logic [WORD_W-1:0] w);
        t_pending item;
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            in_if.valid <= 1'b0;
            in_if.instruction_word <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.instruction_word <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        item.word = w;
        item.dec = predict_decode(w, enables);
        pending_decodes.push_back(item);
    endtask

    // Drop valid and let the pipeline drain
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
    endtask

    // Write every enable register while the decoder is idle
    task automatic apply_cfg(input t_cfg c);
        wait_idle();
        write_reg(CFG_ATOMIC, c.atomic_enable);
        write_reg(CFG_WIDE, c.wide_mode);
        write_reg(CFG_MULDIV, c.muldiv_enable);
        write_reg(CFG_PRIV, c.privileged_enable);
        write_reg(CFG_CSR, c.csr_enable);
        i_cfg_we <= 1'b0;
        enables = c;
    endtask

    // Extensions off straight after reset
    task automatic test_reset_defaults();
        send_word('0);
        send_word('1);
        send_word(encode(7'h7F, 5'd3, 5'd4, F3_AMO_W, 5'd5, OPC_AMO));
        send_word(encode(MRET_IMM[11:5], MRET_IMM[4:0], 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM));
        send_word(encode(F7_MUL, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP));
        send_word(encode(7'h7F, 5'd31, 5'd1, F3_CSRRS, 5'd2, OPC_SYSTEM));
        send_word(encode(F7_BASE, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OPIMMW));
        send_word(encode(F7_BASE, 5'd0, 5'd9, F3_D, 5'd8, OPC_LOAD));
    endtask

    // Field extremes and special cases with every extension on
    task automatic test_directed_wide();
        apply_cfg('1);
        send_word({20'hFFFFF, 5'd31, OPC_LUI});
        send_word({20'h80000, 5'd0, OPC_AUIPC});
        send_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL});
        send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OPC_JAL});
        send_word(encode(7'b1000000, 5'd31, 5'd0, F3_BLT, 5'd0, OPC_BRANCH));
        send_word(encode(F7_BASE, 5'd1, 5'd1, 3'd2, 5'd1, OPC_BRANCH));
        send_word(encode(7'h7F, 5'd31, 5'd31, F3_D, 5'd31, OPC_STORE));
        send_word(encode({SH6_SRA, 1'b1}, 5'd31, 5'd7, F3_SR, 5'd6, OPC_OPIMM));
        send_word(encode(7'b1000000, 5'd1, 5'd7, F3_SLL, 5'd6, OPC_OPIMM));
        send_word(encode(7'h7F, 5'd2, 5'd3, F3_AMO_W, 5'd4, OPC_AMO));
        send_word(encode(F7_BASE, 5'd2, 5'd3, F3_BU, 5'd4, OPC_AMO));
        send_word(encode(MRET_IMM[11:5], MRET_IMM[4:0], 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM));
        send_word(encode(7'h7F, 5'd31, 5'd5, F3_CSRRW, 5'd6, OPC_SYSTEM));
        send_word(encode(F7_BASE, 5'd0, 5'd5, F3_SLTU, 5'd6, OPC_SYSTEM));
        send_word(encode(F7_BASE, 5'd0, 5'd0, F3_H, 5'd0, OPC_FENCE));
        send_word(encode(F7_MUL, 5'd1, 5'd2, 3'd2, 5'd3, OPC_OP));
        send_word(encode(F7_MUL, 5'd1, 5'd2, F3_SR, 5'd3, OPC_OP));
        send_word(encode(F7_BASE, 5'd1, 5'd2, F3_B, 5'd3, OPC_LOAD));
        send_word(encode(7'h7F, 5'd31, 5'd2, F3_D, 5'd3, OPC_LOAD));
    endtask

    // Shift encodings and a doubleword store under the 32-bit word size
    task automatic test_directed_narrow();
        apply_cfg(5'b10111);
        send_word(encode(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd2, OPC_OPIMM));
        send_word(encode(F7_MUL, 5'd31, 5'd1, F3_SR, 5'd2, OPC_OPIMM));
        send_word(encode(F7_MUL, 5'd0, 5'd1, F3_SLL, 5'd2, OPC_OPIMM));
        send_word(encode(7'h7F, 5'd31, 5'd31, F3_D, 5'd31, OPC_STORE));
    endtask

    // Random words under a sequence of enable settings, extremes first
    task automatic test_random_settings();
        t_cfg c;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) c = '0;
            else if (phase == 1) c = '1;
            else c = t_cfg'($urandom_range(0, 31));
            apply_cfg(c);
            repeat (PHASE_WORDS) send_word(random_word());
        end
    endtask

    // Back-to-back words with both sides always ready
    task automatic test_random_calm();
        apply_cfg('1);
        calm = 1'b1;
        repeat (PHASE_WORDS) send_word(random_word());
    endtask

    // Receiver: random stall bursts, occasional free-running stretches
    initial begin : sink_pacing
        int stall;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 14);
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                stall = $urandom_range(20, 80);
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Compare each result beat with the oldest expected decode
    always @(posedge i_clk) begin : check_decoded
        t_pending exp_item;
        t_dec got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.operation = t_op'(out_if.operation);
            got.illegal   = out_if.illegal;
            got.dest_reg  = out_if.dest_reg;
            got.dest_used = out_if.dest_used;
            got.src1_reg  = out_if.src1_reg;
            got.src1_used = out_if.src1_used;
            got.src2_reg  = out_if.src2_reg;
            got.src2_used = out_if.src2_used;
            got.immediate = out_if.immediate;
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", show_dec(got));
            end else begin
                exp_item = pending_decodes.pop_front();
                if (got !== exp_item.dec) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on word %h", exp_item.word);
                        $display("  expected %s", show_dec(exp_item.dec));
                        $display("  actual   %s", show_dec(got));
                    end
                end
            end
        end
    end

    initial begin : run
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_ATOMIC;
        i_cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.instruction_word <= '0;
        enables = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_wide();
        test_directed_narrow();
        test_random_settings();
        test_random_calm();

        // Drain and report
        wait_idle();
        if (mismatches == 0 && pending_decodes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rvid_pkg.sv
rtl/core/rvid_if.sv
rtl/core/riscv_instruction_decoder.sv
rtl/core/rvid_checker.sv
test/tb_riscv_instruction_decoder.sv
